// ===== rtl/core/lphi_pkg.sv =====
// Shared types and constants for the linear-probe hash insert unit.
// No dependencies; imported by the front, back and top-level modules.
package lphi_pkg;

	localparam int TABLE_SIZE = 16;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int KEY_W      = 32;
	localparam int ID_W       = 32;
	localparam int STATUS_W   = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [STATUS_W-1:0] ST_HOME   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PROBED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ROW    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

	// One classified command waiting for the back end
	typedef struct packed {
		logic              is_dump;
		logic [SLOT_W-1:0] home;
		logic [ID_W-1:0]   emp_id;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PROBE,
		BK_SCAN
	} back_state_t;

endpackage

// ===== rtl/core/linear_probe_hash_insert_unit.sv =====
// Top level of the linear-probe hash insert unit: front end with queue,
// back end with the id RAM. Depends on lphi_pkg, lphi_front, lphi_back.
//
//  Channel   Handshake               Fields
//  --------  ----------------------  ----------------------------------------
//  request   start & !busy           req_type, key_value, emp_id
//  result    strobe (one cycle)      status, slot_index, stored_id, last_result
//
//  Flow: the front writes each accepted item into a queue of up to two.
//  The back end takes a command off the queue while idle, then walks the
//  table one slot per cycle: an insert probes 1 to TABLE_SIZE slots, a
//  dump scans up to its highest occupied slot (a dump of an empty table
//  gives only an empty marker), and every result is registered and
//  appears in the cycle after the cycle that decides it.
//  Reset: arst_n clears the occupancy bits (empty table) and the queue;
//  stored ids are not cleared and are only read from occupied slots.
//  Stalls: busy is high while the queue is full; results cannot be held off.
module linear_probe_hash_insert_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           req_type,
	input  logic [lphi_pkg::KEY_W-1:0]     key_value,
	input  logic [lphi_pkg::ID_W-1:0]      emp_id,
	output logic                           strobe,
	output logic [lphi_pkg::STATUS_W-1:0]  status,
	output logic [lphi_pkg::SLOT_W-1:0]    slot_index,
	output logic [lphi_pkg::ID_W-1:0]      stored_id,
	output logic                           last_result
);
	import lphi_pkg::*;

	// queue head handed from front to back
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	lphi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.key_value (key_value),
		.emp_id    (emp_id),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back end owns the occupancy bits and the id RAM
	lphi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.strobe      (strobe),
		.status      (status),
		.slot_index  (slot_index),
		.stored_id   (stored_id),
		.last_result (last_result)
	);

endmodule

// ===== rtl/core/lphi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lphi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/lphi_front.sv =====
// Front end: takes items, classifies them and computes the home slot,
// then holds them in a two-entry queue. Depends on lphi_pkg.
module lphi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [lphi_pkg::KEY_W-1:0]  key_value,
	input  logic [lphi_pkg::ID_W-1:0]   emp_id,
	output logic                        cmd_valid,
	output lphi_pkg::cmd_t              cmd,
	input  logic                        cmd_pop
);
	import lphi_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;
	cmd_t             new_cmd;

	// table size is a power of two, so key mod size is the low bits
	always_comb begin
		new_cmd.is_dump = req_type;
		new_cmd.home    = key_value[SLOT_W-1:0];
		new_cmd.emp_id  = emp_id;
	end

	assign busy      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("back end popped an empty queue");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

endmodule

// ===== rtl/core/lphi_back.sv =====
// Back end: probes the table for inserts and scans it for dumps,
// one slot per cycle. Depends on lphi_pkg and lphi_ram.
module lphi_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  lphi_pkg::cmd_t                 cmd,
	output logic                           cmd_pop,
	output logic                           strobe,
	output logic [lphi_pkg::STATUS_W-1:0]  status,
	output logic [lphi_pkg::SLOT_W-1:0]    slot_index,
	output logic [lphi_pkg::ID_W-1:0]      stored_id,
	output logic                           last_result
);
	import lphi_pkg::*;

	back_state_t           state_q, state_d;
	logic [SLOT_W-1:0]     ptr_q;
	logic [SLOT_W-1:0]     cnt_q;
	logic [ID_W-1:0]       id_q;
	logic [TABLE_SIZE-1:0] used_q;

	logic                  res_strobe_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic [ID_W-1:0]       res_id_q;

	logic                  rd_valid_s1;
	logic [SLOT_W-1:0]     rd_slot_s1;
	logic                  rd_last_s1;

	logic                  load_ins;
	logic                  load_scan;
	logic                  advance;
	logic                  emit;
	logic [STATUS_W-1:0]   emit_status;
	logic [SLOT_W-1:0]     emit_slot;
	logic [ID_W-1:0]       emit_id;
	logic                  ram_we;
	logic                  rd_issue;
	logic                  rd_last;
	logic [ID_W-1:0]       ram_rdata;
	logic [TABLE_SIZE-1:0] upper;
	logic                  more_rows;
	logic                  cur_used;
	logic                  probes_done;
	logic [SLOT_W-1:0]     ptr_next;

	assign cur_used    = used_q[ptr_q];
	assign upper       = used_q >> ptr_q;
	assign more_rows   = |upper[TABLE_SIZE-1:1];
	assign probes_done = (cnt_q == SLOT_W'(TABLE_SIZE - 1));
	assign ptr_next    = (ptr_q == SLOT_W'(TABLE_SIZE - 1)) ? '0 : ptr_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (!cmd.is_dump) begin
						state_d = BK_PROBE;
					end else if (used_q != '0) begin
						state_d = BK_SCAN;
					end
				end
			end
			BK_PROBE: begin
				if (!cur_used || probes_done) begin
					state_d = BK_IDLE;
				end
			end
			BK_SCAN: begin
				if (cur_used && !more_rows) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// actions
	always_comb begin
		cmd_pop     = 1'b0;
		load_ins    = 1'b0;
		load_scan   = 1'b0;
		advance     = 1'b0;
		emit        = 1'b0;
		emit_status = ST_HOME;
		emit_slot   = '0;
		emit_id     = '0;
		ram_we      = 1'b0;
		rd_issue    = 1'b0;
		rd_last     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (!cmd.is_dump) begin
						load_ins = 1'b1;
					end else if (used_q != '0) begin
						load_scan = 1'b1;
					end else begin
						emit        = 1'b1;
						emit_status = ST_EMPTY;
					end
				end
			end
			BK_PROBE: begin
				if (!cur_used) begin
					ram_we      = 1'b1;
					emit        = 1'b1;
					emit_status = (cnt_q == '0) ? ST_HOME : ST_PROBED;
					emit_slot   = ptr_q;
					emit_id     = id_q;
				end else if (probes_done) begin
					emit        = 1'b1;
					emit_status = ST_FULL;
				end else begin
					advance = 1'b1;
				end
			end
			BK_SCAN: begin
				advance = 1'b1;
				if (cur_used) begin
					rd_issue = 1'b1;
					rd_last  = !more_rows;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			used_q       <= '0;
			res_strobe_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_strobe_q <= emit;
			rd_valid_s1  <= rd_issue;
			if (ram_we) begin
				used_q[ptr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ins) begin
			ptr_q <= cmd.home;
			cnt_q <= '0;
			id_q  <= cmd.emp_id;
		end else if (load_scan) begin
			ptr_q <= '0;
		end else if (advance) begin
			ptr_q <= ptr_next;
			cnt_q <= cnt_q + 1'b1;
		end
		if (emit) begin
			res_status_q <= emit_status;
			res_slot_q   <= emit_slot;
			res_id_q     <= emit_id;
		end
		if (rd_issue) begin
			rd_slot_s1 <= ptr_q;
			rd_last_s1 <= rd_last;
		end
	end

	lphi_ram #(
		.WIDTH (ID_W),
		.DEPTH (TABLE_SIZE)
	) u_id_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (id_q),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// dump rows come straight from the RAM read register
	assign strobe      = res_strobe_q || rd_valid_s1;
	assign status      = rd_valid_s1 ? ST_ROW : res_status_q;
	assign slot_index  = rd_valid_s1 ? rd_slot_s1 : res_slot_q;
	assign stored_id   = rd_valid_s1 ? ram_rdata : res_id_q;
	assign last_result = rd_valid_s1 ? rd_last_s1 : 1'b1;

	a_no_result_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_strobe_q && rd_valid_s1))
		else $error("insert result and dump row on the same cycle");

	a_write_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !used_q[ptr_q])
		else $error("write into an occupied slot");

	a_write_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> used_q[$past(ptr_q)])
		else $error("written slot not marked used");

	a_row_is_used: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> used_q[rd_slot_s1])
		else $error("dump row from an empty slot");

endmodule

// ===== sim/tb_linear_probe_hash_insert_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_hash_insert_unit: directed and random
// insert/dump items against an in-bench copy of the hash table. Depends on lphi_pkg.
module tb_linear_probe_hash_insert_unit;

	import lphi_pkg::*;

	// request codes on req_type
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DUMP   = 1'b1;

	// cycles with no accepted item or result before the run is abandoned
	localparam int STALL_LIMIT = 1000;
	// drain time after the last result
	localparam int TAIL_CYCLES = TABLE_SIZE + 4;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [ID_W-1:0]     id;
		logic                last;
	} table_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                req_type;
	logic [KEY_W-1:0]    key_value;
	logic [ID_W-1:0]     emp_id;
	logic                strobe;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [ID_W-1:0]     stored_id;
	logic                last_result;

	// bench copy of the table, updated in acceptance order
	bit                  shadow_used [TABLE_SIZE];
	logic [ID_W-1:0]     shadow_id   [TABLE_SIZE];

	// results predicted but not yet seen on the result ports
	table_result_t       awaited_results [$];
	table_result_t       oldest;

	int                  mismatch_count;
	int                  quiet_cycles;
	bit                  sender_idles;

	linear_probe_hash_insert_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.key_value  (key_value),
		.emp_id     (emp_id),
		.strobe     (strobe),
		.status     (status),
		.slot_index (slot_index),
		.stored_id  (stored_id),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	//--------------------------------------------------------------------
	// Table prediction
	//--------------------------------------------------------------------

	function automatic int occupied_slots();
		int n;
		n = 0;
		for (int s = 0; s < TABLE_SIZE; s++)
			if (shadow_used[s])
				n++;
		return n;
	endfunction

	// Insert: home slot is key mod size, then probe upward with wrap.
	// A full table gives one full result with slot and id zero.
	task automatic predict_insert(input logic [KEY_W-1:0] key, input logic [ID_W-1:0] id);
		table_result_t r;
		int home;
		int s;
		bit placed;
		home   = int'(key % TABLE_SIZE);
		placed = 1'b0;
		for (int step = 0; step < TABLE_SIZE && !placed; step++) begin
			s = (home + step) % TABLE_SIZE;
			if (!shadow_used[s]) begin
				shadow_used[s] = 1'b1;
				shadow_id[s]   = id;
				r.status = (step == 0) ? ST_HOME : ST_PROBED;
				r.slot   = SLOT_W'(s);
				r.id     = id;
				r.last   = 1'b1;
				awaited_results.push_back(r);
				placed = 1'b1;
			end
		end
		if (!placed) begin
			r.status = ST_FULL;
			r.slot   = '0;
			r.id     = '0;
			r.last   = 1'b1;
			awaited_results.push_back(r);
		end
	endtask

	// Dump: one row per occupied slot in ascending order, last row marked;
	// an empty table gives a single empty marker. Key and id are ignored.
	task automatic predict_dump();
		table_result_t r;
		int n;
		int k;
		n = occupied_slots();
		k = 0;
		if (n == 0) begin
			r.status = ST_EMPTY;
			r.slot   = '0;
			r.id     = '0;
			r.last   = 1'b1;
			awaited_results.push_back(r);
		end else begin
			for (int s = 0; s < TABLE_SIZE; s++) begin
				if (shadow_used[s]) begin
					k++;
					r.status = ST_ROW;
					r.slot   = SLOT_W'(s);
					r.id     = shadow_id[s];
					r.last   = (k == n);
					awaited_results.push_back(r);
				end
			end
		end
	endtask

	//--------------------------------------------------------------------
	// Sender side
	//--------------------------------------------------------------------

	// Present one item, hold it until start & !busy at an edge, then predict.
	// start stays high after acceptance; it only drops for an idle gap.
	task automatic send_item(input logic rt, input logic [KEY_W-1:0] key,
	                         input logic [ID_W-1:0] id);
		if (sender_idles && $urandom_range(0, 99) < 20) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start     <= 1'b1;
		req_type  <= rt;
		key_value <= key;
		emp_id    <= id;
		do @(posedge clk); while (busy);
		if (rt == REQ_INSERT)
			predict_insert(key, id);
		else
			predict_dump();
	endtask

	// Stop sending until every predicted result has come back.
	task automatic pause_until_drained();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// key with its home slot pulled into a narrow cluster so probes run long
	function automatic logic [KEY_W-1:0] clustered_key();
		return ($urandom & 32'hFFFF_FFF0) | KEY_W'($urandom_range(0, 5));
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		case ($urandom_range(0, 3))
			0: return KEY_W'($urandom_range(0, TABLE_SIZE - 1));
			1: return '1 - KEY_W'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ID_W-1:0] random_id();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	//--------------------------------------------------------------------
	// Result checking: each strobe is held against the oldest prediction
	//--------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing awaited, status", 32'(status), 32'h0);
			end else begin
				oldest = awaited_results.pop_front();
				if (status !== oldest.status)
					report_mismatch("status", 32'(status), 32'(oldest.status));
				if (slot_index !== oldest.slot)
					report_mismatch("slot_index", 32'(slot_index), 32'(oldest.slot));
				if (stored_id !== oldest.id)
					report_mismatch("stored_id", stored_id, oldest.id);
				if (last_result !== oldest.last)
					report_mismatch("last_result", 32'(last_result), 32'(oldest.last));
			end
		end
	end

	// Watchdog: any accepted item or result restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	//--------------------------------------------------------------------
	// Tests
	//--------------------------------------------------------------------

	// Dumps before any insert: each gives a single empty marker, junk key/id ignored.
	task automatic test_dump_of_empty_table();
		send_item(REQ_DUMP, '1, '1);
		send_item(REQ_DUMP, '0, 32'h5A5A_A5A5);
	endtask

	// Home placement, collision, the top slot and wrap past slot 0.
	task automatic test_home_and_collision();
		send_item(REQ_INSERT, 32'h0000_0000, 32'h0000_0000); // home 0
		send_item(REQ_INSERT, 32'h0000_0010, 32'hFFFF_FFFF); // home 0 taken -> 1
		send_item(REQ_INSERT, 32'hFFFF_FFFF, 32'h1234_5678); // home 15
		send_item(REQ_INSERT, 32'hFFFF_FFFF, 32'h8765_4321); // 15,0,1 taken -> wraps to 2
		send_item(REQ_INSERT, 32'h8000_0007, 32'hDEAD_BEEF); // home 7, high key bit
		send_item(REQ_DUMP,   32'hFFFF_FFFF, 32'h0000_0000);
		send_item(REQ_INSERT, 32'h0000_0001, 32'hCAFE_F00D); // runs 1,2 -> 3
		send_item(REQ_DUMP,   32'h0000_0000, 32'hFFFF_FFFF);
	endtask

	// Fill the rest with keys crowded onto a few homes so probes get long,
	// dumps in between to show the table growing.
	task automatic test_fill_with_clustered_keys();
		while (occupied_slots() < TABLE_SIZE) begin
			if ($urandom_range(0, 99) < 25)
				send_item(REQ_DUMP, $urandom, $urandom);
			else if ($urandom_range(0, 1) == 0)
				send_item(REQ_INSERT, clustered_key(), random_id());
			else
				send_item(REQ_INSERT, random_key(), random_id());
		end
	endtask

	// Table full: inserts are refused and change nothing, dump lists all slots.
	task automatic test_full_table();
		send_item(REQ_INSERT, '0, 32'h0BAD_0BAD);
		send_item(REQ_INSERT, '1, '1);
		send_item(REQ_DUMP, '0, '0);
		send_item(REQ_INSERT, 32'h0000_0009, '0);
		send_item(REQ_DUMP, '1, '1);
	endtask

	// Mixed traffic on the full table; first stretch back to back, then with gaps.
	task automatic test_random_traffic(input int items);
		for (int i = 0; i < items; i++) begin
			sender_idles = (i >= 120);
			if ($urandom_range(0, 99) < 30)
				send_item(REQ_DUMP, $urandom, $urandom);
			else
				send_item(REQ_INSERT, random_key(), random_id());
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		req_type       = REQ_INSERT;
		key_value      = '0;
		emp_id         = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		sender_idles   = 1'b1;
		for (int s = 0; s < TABLE_SIZE; s++) begin
			shadow_used[s] = 1'b0;
			shadow_id[s]   = '0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dump_of_empty_table();
		test_home_and_collision();
		pause_until_drained();
		test_fill_with_clustered_keys();
		pause_until_drained();
		test_full_table();
		test_random_traffic(370);

		// all items sent: wait for the tail, then the block's own latency
		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && awaited_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (awaited_results.size() != 0)
				report_mismatch("results never seen, count", 32'(awaited_results.size()), 32'h0);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
